FILE: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;   // block index / link width
    localparam int CNT_W      = 7;   // block count width (0..MAX_BLOCKS)

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_EMPTY   = 2'd1,
        STS_DOUBLE  = 2'd2,
        STS_INVALID = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // one entry of the block table
    typedef struct packed {
        logic             in_use;
        logic [IDX_W-1:0] link;
    } t_entry;

    // request from the control logic to the block table
    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ram_req;

endpackage

FILE: rtl/core/fbpa_link_ram.sv
module fbpa_link_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbpa_pkg::t_ram_req i_req,
    output fbpa_pkg::t_entry  o_rd_entry
);
    import fbpa_pkg::*;

    t_entry                r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_valid;
    t_entry                r_rd_data;
    logic                  r_rd_valid;
    logic [IDX_W-1:0]      r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // an entry never written since init reads as free, linked to its successor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_entry = r_rd_data;
        end else begin
            o_rd_entry.in_use = 1'b0;
            o_rd_entry.link   = r_rd_addr + IDX_W'(1);
        end
    end

endmodule

FILE: rtl/core/fbpa_ctrl.sv
module fbpa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_opcode,
    input  logic [6:0]                 i_block_index,
    input  logic                       i_cfg_we,
    input  logic [6:0]                 i_cfg_data,
    input  fbpa_pkg::t_entry           i_rd_entry,
    output fbpa_pkg::t_ram_req         o_req,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [fbpa_pkg::IDX_W-1:0] o_granted_index,
    output logic [fbpa_pkg::CNT_W-1:0] o_free_blocks
);
    import fbpa_pkg::*;

    t_state           r_state, n_state;
    t_opcode          r_op, n_op;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_pool, n_pool;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_granted, n_granted;
    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] cfg_sat;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_sat = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(MAX_BLOCKS)) begin
            cfg_sat = CNT_W'(MAX_BLOCKS);
        end else begin
            cfg_sat = i_cfg_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_pool    = r_pool;
        n_head    = r_head;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_granted = r_granted;
        n_free    = r_free;
        o_req     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op        = t_opcode'(i_opcode);
                    n_idx       = i_block_index;
                    o_req.rd_en = 1'b1;
                    o_req.rd_addr = (t_opcode'(i_opcode) == OP_ACQUIRE) ?
                                    r_head : i_block_index[IDX_W-1:0];
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_valid   = 1'b1;
                n_granted = '0;
                n_status  = STS_OK;
                if (r_op == OP_ACQUIRE) begin
                    if (r_count == '0 || {1'b0, r_head} >= r_pool) begin
                        n_status = STS_EMPTY;
                    end else begin
                        o_req.wr_en          = 1'b1;
                        o_req.wr_addr        = r_head;
                        o_req.wr_data.in_use = 1'b1;
                        o_req.wr_data.link   = i_rd_entry.link;
                        n_granted            = r_head;
                        n_head               = i_rd_entry.link;
                        n_count              = r_count - CNT_W'(1);
                    end
                end else begin
                    if (r_idx >= r_pool) begin
                        n_status = STS_INVALID;
                    end else if (!i_rd_entry.in_use) begin
                        n_status = STS_DOUBLE;
                    end else begin
                        o_req.wr_en          = 1'b1;
                        o_req.wr_addr        = r_idx[IDX_W-1:0];
                        o_req.wr_data.in_use = 1'b0;
                        o_req.wr_data.link   = r_head;
                        n_head               = r_idx[IDX_W-1:0];
                        n_count              = r_count + CNT_W'(1);
                    end
                end
                n_free  = n_count;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // cfg write resets the pool; write only while idle, unchecked
        if (i_cfg_we) begin
            n_pool      = cfg_sat;
            n_head      = '0;
            n_count     = cfg_sat;
            o_req.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pool  <= CNT_W'(MAX_BLOCKS);
            r_head  <= '0;
            r_count <= CNT_W'(MAX_BLOCKS);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_free    <= n_free;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_free_blocks   = r_free;

endmodule

FILE: rtl/core/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool with a LIFO free list. Pulse start while busy is low
// with an opcode (acquire or release) and, for release, a block index. The
// result (status, granted index, free count) is registered at the end of
// the execute state and appears for exactly one cycle with o_valid high; it
// cannot be held off, so capture it when o_valid is seen. An operation first
// reads the block table (a synchronous read issued as start is taken) and
// then, in the execute state, checks, updates and writes back the entry. busy
// is high during the execute state only, so a new transaction can be issued
// in the cycle the result is shown.
// Writing the block-count register (the user must do so only while no
// operation is pending; the block does not enforce this) frees all blocks at
// once with no sweep; values of 0 read as 1 and values above 64 as 64.
module fixed_block_pool_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_opcode,
    input  logic [6:0] i_block_index,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [5:0] o_granted_index,
    output logic [6:0] o_free_blocks
);
    import fbpa_pkg::*;

    t_ram_req ram_req;
    t_entry   rd_entry;

    fbpa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_block_index   (i_block_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_rd_entry      (rd_entry),
        .o_req           (ram_req),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_blocks   (o_free_blocks)
    );

    fbpa_link_ram u_link_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (ram_req),
        .o_rd_entry (rd_entry)
    );

endmodule
